[src/pose_frame_rotation_core_macros.svh]
// assertion helpers shared by the pose rotation core
`ifndef POSE_FRAME_ROTATION_CORE_MACROS_SVH
`define POSE_FRAME_ROTATION_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define PFR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("pose rotation core check failed");

// next-cycle implication, disabled while reset is low
`define PFR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("pose rotation core check failed");

`endif

[src/pfr_pkg.sv]
`default_nettype none

package pfr_pkg;

    // cordic iteration count and angle constants
    localparam int CORDIC_STEPS = 16;
    localparam int SQRT_STEPS   = 17;
    localparam int ATAN_LAT     = CORDIC_STEPS + 3;
    localparam int SINCOS_LAT   = CORDIC_STEPS + 1;
    // products, sums, sqrt, atan2, angle fixup, sincos, four multiply stages
    localparam int DEPTH        = 2 + SQRT_STEPS + ATAN_LAT + 1 + SINCOS_LAT + 4;

    localparam logic signed [31:0] INV_GAIN = 32'sd652032874;
    localparam logic signed [17:0] ANG_PI   = 18'sd32768;
    localparam logic signed [17:0] ANG_HALF = 18'sd16384;

    // position lane carried next to the orientation math
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } pos_t;

    // atan2 operands waiting out the square roots
    typedef struct packed {
        logic signed [33:0] sinr;
        logic signed [33:0] cosr;
        logic signed [33:0] siny;
        logic signed [33:0] cosy;
    } trig_t;

    // one restoring square root step
    typedef struct packed {
        logic [33:0] v;
        logic [33:0] r;
    } sq_t;

    // atan2 special case flags
    typedef struct packed {
        logic xneg;
        logic yneg;
        logic xzero;
        logic yzero;
    } at_flag_t;

    // arctangent table, 65536 = pi
    function automatic logic signed [17:0] atan_tab(input logic [3:0] i);
        logic signed [17:0] v;
        case (i)
            4'd0:    v = 18'sd16384;
            4'd1:    v = 18'sd9672;
            4'd2:    v = 18'sd5110;
            4'd3:    v = 18'sd2594;
            4'd4:    v = 18'sd1302;
            4'd5:    v = 18'sd652;
            4'd6:    v = 18'sd326;
            4'd7:    v = 18'sd163;
            4'd8:    v = 18'sd81;
            4'd9:    v = 18'sd41;
            4'd10:   v = 18'sd20;
            4'd11:   v = 18'sd10;
            4'd12:   v = 18'sd5;
            4'd13:   v = 18'sd3;
            4'd14:   v = 18'sd1;
            default: v = 18'sd1;
        endcase
        return v;
    endfunction

    // position of the highest set bit
    function automatic logic [5:0] msb_pos(input logic [33:0] v);
        logic [5:0] p;
        p = '0;
        for (int i = 0; i < 34; i++) begin
            if (v[i]) p = 6'(i);
        end
        return p;
    endfunction

    function automatic sq_t sqrt_step(input sq_t s, input logic [33:0] bt);
        sq_t o;
        logic [34:0] t;
        t = {1'b0, s.r} + {1'b0, bt};
        if ({1'b0, s.v} >= t) begin
            o.v = s.v - t[33:0];
            o.r = (s.r >> 1) + bt;
        end else begin
            o.v = s.v;
            o.r = s.r >> 1;
        end
        return o;
    endfunction

    // round half up and drop 30 fraction bits
    function automatic logic signed [31:0] rnd30(input logic signed [63:0] v);
        logic signed [63:0] t;
        t = (v + 64'sd536870912) >>> 30;
        return t[31:0];
    endfunction

endpackage

`default_nettype wire

[src/pfr_atan2.sv]
`default_nettype none

module pfr_atan2 (
    input  logic               aclk,
    input  logic               en,
    input  logic signed [33:0] sy_i,
    input  logic signed [33:0] sx_i,
    output logic signed [16:0] ang_o
);

    localparam int N = pfr_pkg::CORDIC_STEPS;

    logic [33:0] ax, ay, mx;
    logic [33:0] ax_reg, ay_reg;
    logic [5:0]  msb_reg;
    pfr_pkg::at_flag_t fl_in, fl_reg;

    // magnitudes, special cases and leading bit
    always_comb begin
        ax = sx_i[33] ? (34'd0 - sx_i) : sx_i;
        ay = sy_i[33] ? (34'd0 - sy_i) : sy_i;
        mx = (ax > ay) ? ax : ay;
        fl_in.xneg  = sx_i[33];
        fl_in.yneg  = sy_i[33];
        fl_in.xzero = (ax == '0);
        fl_in.yzero = (ay == '0);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ax_reg  <= ax;
            ay_reg  <= ay;
            msb_reg <= pfr_pkg::msb_pos(mx);
            fl_reg  <= fl_in;
        end
    end

    logic signed [32:0] cx_reg [N+1];
    logic signed [32:0] cy_reg [N+1];
    logic signed [17:0] cz_reg [N+1];
    pfr_pkg::at_flag_t  cf_reg [N+1];
    logic [33:0] xs, ys;
    logic [5:0]  sh;

    // normalize so the larger part lands in [2^29, 2^30)
    always_comb begin
        if (msb_reg >= 6'd30) begin
            sh = msb_reg - 6'd29;
            xs = ax_reg >> sh;
            ys = ay_reg >> sh;
        end else begin
            sh = 6'd29 - msb_reg;
            xs = ax_reg << sh;
            ys = ay_reg << sh;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cx_reg[0] <= $signed({2'b00, xs[30:0]});
            cy_reg[0] <= $signed({2'b00, ys[30:0]});
            cz_reg[0] <= '0;
            cf_reg[0] <= fl_reg;
        end
    end

    // vectoring iterations, one per stage
    for (genvar i = 0; i < N; i++) begin : g_vec
        logic signed [32:0] x_next, y_next;
        logic signed [17:0] z_next;
        always_comb begin
            if (cy_reg[i] >= 0) begin
                x_next = cx_reg[i] + (cy_reg[i] >>> i);
                y_next = cy_reg[i] - (cx_reg[i] >>> i);
                z_next = cz_reg[i] + pfr_pkg::atan_tab(4'(i));
            end else begin
                x_next = cx_reg[i] - (cy_reg[i] >>> i);
                y_next = cy_reg[i] + (cx_reg[i] >>> i);
                z_next = cz_reg[i] - pfr_pkg::atan_tab(4'(i));
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                cx_reg[i+1] <= x_next;
                cy_reg[i+1] <= y_next;
                cz_reg[i+1] <= z_next;
                cf_reg[i+1] <= cf_reg[i];
            end
        end
    end

    logic signed [17:0] zc, a18;
    logic signed [16:0] ang_reg;
    logic signed [16:0] ang_next;

    // clamp, halve and fold into the right quadrant
    always_comb begin
        zc = cz_reg[N];
        if (zc < 0) zc = '0;
        if (zc > pfr_pkg::ANG_PI) zc = pfr_pkg::ANG_PI;
        a18 = (zc + 18'sd1) >>> 1;
        if (cf_reg[N].xzero) a18 = pfr_pkg::ANG_HALF;
        if (cf_reg[N].xneg) a18 = pfr_pkg::ANG_PI - a18;
        if (cf_reg[N].yneg) a18 = -a18;
        if (cf_reg[N].yzero) a18 = cf_reg[N].xneg ? pfr_pkg::ANG_PI : 18'sd0;
        ang_next = a18[16:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ang_reg <= ang_next;
        end
    end

    assign ang_o = ang_reg;

endmodule

`default_nettype wire

[src/pfr_sincos.sv]
`default_nettype none

module pfr_sincos (
    input  logic               aclk,
    input  logic               en,
    input  logic [16:0]        ang_i,
    output logic signed [31:0] cos_o,
    output logic signed [31:0] sin_o
);

    localparam int N = pfr_pkg::CORDIC_STEPS;
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;

    logic signed [31:0] x_reg [N];
    logic signed [31:0] y_reg [N];
    logic signed [17:0] z_reg [N];
    logic [1:0]         q_reg [N];

    // rotation iterations; the first starts from the fixed vector
    for (genvar i = 0; i < N; i++) begin : g_rot
        logic signed [31:0] x_in, y_in, x_next, y_next;
        logic signed [17:0] z_in, z_next;
        logic [1:0]         q_in;
        if (i == 0) begin : g_first
            assign x_in = pfr_pkg::INV_GAIN;
            assign y_in = '0;
            assign z_in = $signed({3'b000, ang_i[14:0]});
            assign q_in = ang_i[16:15];
        end else begin : g_rest
            assign x_in = x_reg[i-1];
            assign y_in = y_reg[i-1];
            assign z_in = z_reg[i-1];
            assign q_in = q_reg[i-1];
        end
        always_comb begin
            if (z_in >= 0) begin
                x_next = x_in - (y_in >>> i);
                y_next = y_in + (x_in >>> i);
                z_next = z_in - pfr_pkg::atan_tab(4'(i));
            end else begin
                x_next = x_in + (y_in >>> i);
                y_next = y_in - (x_in >>> i);
                z_next = z_in + pfr_pkg::atan_tab(4'(i));
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg[i] <= x_next;
                y_reg[i] <= y_next;
                z_reg[i] <= z_next;
                q_reg[i] <= q_in;
            end
        end
    end

    logic signed [31:0] c_next, s_next, c_reg, s_reg;

    // quadrant map
    always_comb begin
        case (q_reg[N-1])
            QUAD_0: begin
                c_next = x_reg[N-1];
                s_next = y_reg[N-1];
            end
            QUAD_1: begin
                c_next = -y_reg[N-1];
                s_next = x_reg[N-1];
            end
            QUAD_2: begin
                c_next = -x_reg[N-1];
                s_next = -y_reg[N-1];
            end
            default: begin
                c_next = y_reg[N-1];
                s_next = -x_reg[N-1];
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c_reg <= c_next;
            s_reg <= s_next;
        end
    end

    assign cos_o = c_reg;
    assign sin_o = s_reg;

endmodule

`default_nettype wire

[src/pose_frame_rotation_core.sv]
`default_nettype none
// channel   | handshake          | payload
// ----------+--------------------+-------------------------------------------
// s_        | s_valid / s_ready  | pos x,y,z Q16.16, quat w,x,y,z Q2.14
// m_        | m_valid / m_ready  | out x,y,z Q16.16, out qw,qx,qy,qz Q2.14
// cfg_      | cfg_we             | yaw offset, 18 bit signed, 32768 = pi
//
// one request per cycle unless the output stalls; the two 17-step square roots,
// the 16-step atan2 and sincos cordic chains and the four multiply stages
// all sit in one shared pipeline.
// synchronous active-low reset clears valid bits and sets yaw offset to pi/2.
// a result not taken freezes the whole pipeline; s_ready drops meanwhile.

module pose_frame_rotation_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic signed [17:0] cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_pos_x,
    input  logic signed [31:0] s_pos_y,
    input  logic signed [31:0] s_pos_z,
    input  logic signed [15:0] s_quat_w,
    input  logic signed [15:0] s_quat_x,
    input  logic signed [15:0] s_quat_y,
    input  logic signed [15:0] s_quat_z,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_out_x,
    output logic signed [31:0] m_out_y,
    output logic signed [31:0] m_out_z,
    output logic signed [15:0] m_out_qw,
    output logic signed [15:0] m_out_qx,
    output logic signed [15:0] m_out_qy,
    output logic signed [15:0] m_out_qz
);

`include "pose_frame_rotation_core_macros.svh"

    localparam int D  = pfr_pkg::DEPTH;
    localparam int SQ = pfr_pkg::SQRT_STEPS;

    logic         en;
    logic [D-1:0] vld_reg;
    logic signed [17:0] yaw_offset_reg;

    // pipeline advances unless the last result is held
    assign en      = !vld_reg[D-1] || m_ready;
    assign s_ready = en;
    assign m_valid = vld_reg[D-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[D-2:0], s_valid};
        end
    end

    // yaw offset register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            yaw_offset_reg <= 18'sd16384;
        end else if (cfg_we) begin
            yaw_offset_reg <= cfg_wdata;
        end
    end

    // position lane: rotate at entry, then delay
    pfr_pkg::pos_t pos_reg [D];
    pfr_pkg::pos_t pos_in;

    always_comb begin
        pos_in.x = (s_pos_y == 32'sh80000000) ? 32'sh7fffffff : -s_pos_y;
        pos_in.y = s_pos_x;
        pos_in.z = s_pos_z;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pos_reg[0] <= pos_in;
        end
    end

    for (genvar k = 1; k < D; k++) begin : g_pos
        always_ff @(posedge aclk) begin
            if (en) begin
                pos_reg[k] <= pos_reg[k-1];
            end
        end
    end

    // quaternion products
    logic signed [31:0] p_wx_reg, p_yz_reg, p_xx_reg, p_yy_reg, p_zz_reg;
    logic signed [31:0] p_wz_reg, p_xy_reg, p_wy_reg, p_xz_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            p_wx_reg <= s_quat_w * s_quat_x;
            p_yz_reg <= s_quat_y * s_quat_z;
            p_xx_reg <= s_quat_x * s_quat_x;
            p_yy_reg <= s_quat_y * s_quat_y;
            p_zz_reg <= s_quat_z * s_quat_z;
            p_wz_reg <= s_quat_w * s_quat_z;
            p_xy_reg <= s_quat_x * s_quat_y;
            p_wy_reg <= s_quat_w * s_quat_y;
            p_xz_reg <= s_quat_x * s_quat_z;
        end
    end

    // atan2 operands and clamped sqrt arguments
    pfr_pkg::trig_t trig_reg [SQ+1];
    pfr_pkg::trig_t trig_next;
    pfr_pkg::sq_t   sqa_reg [SQ+1];
    pfr_pkg::sq_t   sqb_reg [SQ+1];
    logic signed [33:0] t34;
    logic signed [34:0] a35, b35;

    always_comb begin
        trig_next.sinr = (34'(p_wx_reg) + 34'(p_yz_reg)) <<< 1;
        trig_next.cosr = 34'sd268435456 - ((34'(p_xx_reg) + 34'(p_yy_reg)) <<< 1);
        trig_next.siny = (34'(p_wz_reg) + 34'(p_xy_reg)) <<< 1;
        trig_next.cosy = 34'sd268435456 - ((34'(p_yy_reg) + 34'(p_zz_reg)) <<< 1);
        t34 = (34'(p_wy_reg) - 34'(p_xz_reg)) <<< 1;
        a35 = 35'sd268435456 + 35'(t34);
        b35 = 35'sd268435456 - 35'(t34);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            trig_reg[0] <= trig_next;
            sqa_reg[0].v <= a35[34] ? 34'd0 : a35[33:0];
            sqa_reg[0].r <= '0;
            sqb_reg[0].v <= b35[34] ? 34'd0 : b35[33:0];
            sqb_reg[0].r <= '0;
        end
    end

    // square roots, one result bit per stage
    for (genvar k = 0; k < SQ; k++) begin : g_sqrt
        localparam logic [33:0] BT = 34'd1 << (2 * (SQ - 1 - k));
        always_ff @(posedge aclk) begin
            if (en) begin
                sqa_reg[k+1]  <= pfr_pkg::sqrt_step(sqa_reg[k], BT);
                sqb_reg[k+1]  <= pfr_pkg::sqrt_step(sqb_reg[k], BT);
                trig_reg[k+1] <= trig_reg[k];
            end
        end
    end

    // three atan2 units in lockstep
    logic signed [16:0] ang_r, ang_p, ang_y;

    pfr_atan2 u_atan_roll (
        .aclk (aclk),
        .en   (en),
        .sy_i (trig_reg[SQ].sinr),
        .sx_i (trig_reg[SQ].cosr),
        .ang_o(ang_r)
    );

    pfr_atan2 u_atan_pitch (
        .aclk (aclk),
        .en   (en),
        .sy_i ($signed({1'b0, sqa_reg[SQ].r[32:0]})),
        .sx_i ($signed({1'b0, sqb_reg[SQ].r[32:0]})),
        .ang_o(ang_p)
    );

    pfr_atan2 u_atan_yaw (
        .aclk (aclk),
        .en   (en),
        .sy_i (trig_reg[SQ].siny),
        .sx_i (trig_reg[SQ].cosy),
        .ang_o(ang_y)
    );

    // pitch fixup, yaw offset and single wrap
    logic signed [18:0] pitch19, yaw19;
    logic [16:0] roll_ang_reg, pitch_ang_reg, yaw_ang_reg;

    always_comb begin
        pitch19 = (19'(ang_p) <<< 1) - 19'sd16384;
        yaw19   = 19'(ang_y) + 19'(yaw_offset_reg);
        if (yaw19 > 19'sd65536) yaw19 = yaw19 - 19'sd65536;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            roll_ang_reg  <= ang_r;
            pitch_ang_reg <= pitch19[16:0];
            yaw_ang_reg   <= yaw19[16:0];
        end
    end

    // half-angle sines and cosines
    logic signed [31:0] cr, sr, cp, sp, cy, sy;

    pfr_sincos u_sc_roll (
        .aclk (aclk), .en(en), .ang_i(roll_ang_reg), .cos_o(cr), .sin_o(sr)
    );

    pfr_sincos u_sc_pitch (
        .aclk (aclk), .en(en), .ang_i(pitch_ang_reg), .cos_o(cp), .sin_o(sp)
    );

    pfr_sincos u_sc_yaw (
        .aclk (aclk), .en(en), .ang_i(yaw_ang_reg), .cos_o(cy), .sin_o(sy)
    );

    // first products of the rebuild, rounded to q30
    logic signed [63:0] m_cc, m_ss, m_sc, m_cs;
    logic signed [31:0] r_cc_reg, r_ss_reg, r_sc_reg, r_cs_reg;
    logic signed [31:0] cy_reg, sy_reg;

    always_comb begin
        m_cc = cr * cp;
        m_ss = sr * sp;
        m_sc = sr * cp;
        m_cs = cr * sp;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r_cc_reg <= pfr_pkg::rnd30(m_cc);
            r_ss_reg <= pfr_pkg::rnd30(m_ss);
            r_sc_reg <= pfr_pkg::rnd30(m_sc);
            r_cs_reg <= pfr_pkg::rnd30(m_cs);
            cy_reg   <= cy;
            sy_reg   <= sy;
        end
    end

    // second products
    logic signed [63:0] t_ccc_reg, t_sss_reg, t_scc_reg, t_css_reg;
    logic signed [63:0] t_csc_reg, t_scs_reg, t_ccs_reg, t_ssc_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            t_ccc_reg <= r_cc_reg * cy_reg;
            t_sss_reg <= r_ss_reg * sy_reg;
            t_scc_reg <= r_sc_reg * cy_reg;
            t_css_reg <= r_cs_reg * sy_reg;
            t_csc_reg <= r_cs_reg * cy_reg;
            t_scs_reg <= r_sc_reg * sy_reg;
            t_ccs_reg <= r_cc_reg * sy_reg;
            t_ssc_reg <= r_ss_reg * cy_reg;
        end
    end

    // round and combine into q30 components
    logic signed [32:0] qw_sum_reg, qx_sum_reg, qy_sum_reg, qz_sum_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            qw_sum_reg <= 33'(pfr_pkg::rnd30(t_ccc_reg)) + 33'(pfr_pkg::rnd30(t_sss_reg));
            qx_sum_reg <= 33'(pfr_pkg::rnd30(t_scc_reg)) - 33'(pfr_pkg::rnd30(t_css_reg));
            qy_sum_reg <= 33'(pfr_pkg::rnd30(t_csc_reg)) + 33'(pfr_pkg::rnd30(t_scs_reg));
            qz_sum_reg <= 33'(pfr_pkg::rnd30(t_ccs_reg)) - 33'(pfr_pkg::rnd30(t_ssc_reg));
        end
    end

    // q30 to q2.14 with saturation
    function automatic logic signed [15:0] to_q14(input logic signed [32:0] v);
        logic signed [33:0] t;
        logic signed [15:0] r;
        t = (34'(v) + 34'sd32768) >>> 16;
        if (t > 34'sd16384) r = 16'sd16384;
        else if (t < -34'sd16384) r = -16'sd16384;
        else r = t[15:0];
        return r;
    endfunction

    logic signed [15:0] qw_reg, qx_reg, qy_reg, qz_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            qw_reg <= to_q14(qw_sum_reg);
            qx_reg <= to_q14(qx_sum_reg);
            qy_reg <= to_q14(qy_sum_reg);
            qz_reg <= to_q14(qz_sum_reg);
        end
    end

    assign m_out_x  = pos_reg[D-1].x;
    assign m_out_y  = pos_reg[D-1].y;
    assign m_out_z  = pos_reg[D-1].z;
    assign m_out_qw = qw_reg;
    assign m_out_qx = qx_reg;
    assign m_out_qy = qy_reg;
    assign m_out_qz = qz_reg;

    // checks
    `PFR_ASSERT_NXT(a_accept_enters, aclk, aresetn, s_valid && s_ready, vld_reg[0])
    `PFR_ASSERT_IMP(a_stall_blocks_input, aclk, aresetn, m_valid && !m_ready, !s_ready)
    `PFR_ASSERT_NXT(a_tail_reaches_out, aclk, aresetn, en && vld_reg[D-2], m_valid)
    `PFR_ASSERT_IMP(a_quat_in_range, aclk, aresetn, m_valid, (m_out_qw <= 16'sd16384) && (m_out_qw >= -16'sd16384) && (m_out_qz <= 16'sd16384) && (m_out_qz >= -16'sd16384))

endmodule

`default_nettype wire

[bench/tb.sv]
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // one pose request and the pose that comes back
    typedef struct {
        logic signed [31:0] px, py, pz;
        logic signed [15:0] qw, qx, qy, qz;
    } pose_req_t;

    typedef struct {
        logic signed [31:0] ox, oy, oz;
        logic signed [15:0] qw, qx, qy, qz;
    } pose_res_t;

    localparam longint ONE_Q28  = 64'sd268435456;
    localparam longint HALF_TURN = 64'sd32768;
    localparam int     PIPE_WAIT = 80;

    localparam longint ATAN_STEP [16] = '{16384, 9672, 5110, 2594, 1302, 652, 326, 163,
                                          81, 41, 20, 10, 5, 3, 1, 1};

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_we = 1'b0;
    logic signed [17:0] cfg_wdata = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [31:0] s_pos_x = '0, s_pos_y = '0, s_pos_z = '0;
    logic signed [15:0] s_quat_w = '0, s_quat_x = '0, s_quat_y = '0, s_quat_z = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [31:0] m_out_x, m_out_y, m_out_z;
    logic signed [15:0] m_out_qw, m_out_qx, m_out_qy, m_out_qz;

    pose_req_t          pending_q[$];
    pose_res_t          rotated_q[$];
    logic signed [17:0] yaw_offset_reg = 18'sd16384;
    int                 mismatches = 0;
    int                 send_idle_pct = 0;
    int                 recv_stall_pct = 0;
    bit                 req_taken = 1'b0;
    bit                 hold_start = 1'b0;
    int                 hold_left = 0;

    pose_frame_rotation_core i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_pos_x(s_pos_x), .s_pos_y(s_pos_y), .s_pos_z(s_pos_z),
        .s_quat_w(s_quat_w), .s_quat_x(s_quat_x), .s_quat_y(s_quat_y), .s_quat_z(s_quat_z),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_out_x(m_out_x), .m_out_y(m_out_y), .m_out_z(m_out_z),
        .m_out_qw(m_out_qw), .m_out_qx(m_out_qx), .m_out_qy(m_out_qy), .m_out_qz(m_out_qz)
    );

    // clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // floor square root
    function automatic longint root_floor(input longint v);
        longint r, b;
        r = 0;
        b = 64'sd1 <<< 62;
        while (b > v) b = b >>> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >>> 1) + b;
            end else begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        return r;
    endfunction

    // vectoring cordic, 32768 = pi
    function automatic longint angle_of(input longint sy, input longint sx);
        longint ax, ay, mx, x, y, z, nx, a;
        ax = (sx < 0) ? -sx : sx;
        ay = (sy < 0) ? -sy : sy;
        if (ay == 0) return (sx < 0) ? HALF_TURN : 0;
        if (ax == 0) begin
            a = 16384;
        end else begin
            mx = (ax > ay) ? ax : ay;
            while (mx >= 64'sd1073741824) begin
                ax = ax >>> 1; ay = ay >>> 1; mx = mx >>> 1;
            end
            while (mx < 64'sd536870912) begin
                ax = ax <<< 1; ay = ay <<< 1; mx = mx <<< 1;
            end
            x = ax; y = ay; z = 0;
            for (int i = 0; i < 16; i++) begin
                if (y >= 0) begin
                    nx = x + (y >>> i); y = y - (x >>> i); z = z + ATAN_STEP[i];
                end else begin
                    nx = x - (y >>> i); y = y + (x >>> i); z = z - ATAN_STEP[i];
                end
                x = nx;
            end
            if (z < 0) z = 0;
            if (z > 32768) z = 32768;
            a = (z + 1) >>> 1;
        end
        if (sx < 0) a = HALF_TURN - a;
        if (sy < 0) a = -a;
        return a;
    endfunction

    // half-angle cos and sin in q30, angle taken as 65536 = pi
    function automatic void half_sincos(input longint ang, output longint c, output longint s);
        longint p, x, y, z, nx;
        int quad;
        p = ang & 64'h1FFFF;
        quad = int'(p >>> 15);
        x = 652032874; y = 0; z = p & 64'h7FFF;
        for (int i = 0; i < 16; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i); y = y + (x >>> i); z = z - ATAN_STEP[i];
            end else begin
                nx = x + (y >>> i); y = y - (x >>> i); z = z + ATAN_STEP[i];
            end
            x = nx;
        end
        case (quad)
            0:       begin c = x;  s = y;  end
            1:       begin c = -y; s = x;  end
            2:       begin c = -x; s = -y; end
            default: begin c = y;  s = -x; end
        endcase
    endfunction

    function automatic longint prod3(input longint a, input longint b, input longint c);
        longint t;
        t = (a * b + (64'sd1 <<< 29)) >>> 30;
        return (t * c + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function automatic logic signed [15:0] to_q2_14(input longint v);
        longint r;
        r = (v + 64'sd32768) >>> 16;
        if (r > 16384) r = 16384;
        if (r < -16384) r = -16384;
        return 16'(r);
    endfunction

    // rotated pose for one request under the current yaw offset
    function automatic pose_res_t rotate_pose(input pose_req_t rq);
        pose_res_t rs;
        longint w, x, y, z, t, a, b, roll, pitch, yaw, nx;
        longint cr, sr, cp, sp, cy, sy;
        w = rq.qw; x = rq.qx; y = rq.qy; z = rq.qz;
        nx = -longint'(rq.py);
        if (nx > 64'sd2147483647) nx = 64'sd2147483647;
        rs.ox = 32'(nx);
        rs.oy = rq.px;
        rs.oz = rq.pz;
        roll = angle_of(2 * (w * x + y * z), ONE_Q28 - 2 * (x * x + y * y));
        t = 2 * (w * y - x * z);
        a = ONE_Q28 + t; if (a < 0) a = 0;
        b = ONE_Q28 - t; if (b < 0) b = 0;
        pitch = 2 * angle_of(root_floor(a), root_floor(b)) - 16384;
        yaw = angle_of(2 * (w * z + x * y), ONE_Q28 - 2 * (y * y + z * z));
        yaw = yaw + longint'(yaw_offset_reg);
        if (yaw > 2 * HALF_TURN) yaw = yaw - 2 * HALF_TURN;
        half_sincos(roll, cr, sr);
        half_sincos(pitch, cp, sp);
        half_sincos(yaw, cy, sy);
        rs.qw = to_q2_14(prod3(cr, cp, cy) + prod3(sr, sp, sy));
        rs.qx = to_q2_14(prod3(sr, cp, cy) - prod3(cr, sp, sy));
        rs.qy = to_q2_14(prod3(cr, sp, cy) + prod3(sr, cp, sy));
        rs.qz = to_q2_14(prod3(cr, cp, sy) - prod3(sr, sp, cy));
        return rs;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch on %s at %0t: got %0d, want %0d", what, $time, got, want);
        mismatches++;
    endtask

    // accept requests and check results at the rising edge
    always @(posedge aclk) begin
        pose_req_t rq;
        pose_res_t ex;
        req_taken = 1'b0;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                rq.px = s_pos_x; rq.py = s_pos_y; rq.pz = s_pos_z;
                rq.qw = s_quat_w; rq.qx = s_quat_x; rq.qy = s_quat_y; rq.qz = s_quat_z;
                rotated_q.push_back(rotate_pose(rq));
                req_taken = 1'b1;
            end
            if (m_valid && m_ready) begin
                if (rotated_q.size() == 0) begin
                    report_mismatch("unexpected result", 0, 0);
                end else begin
                    ex = rotated_q.pop_front();
                    if (m_out_x != ex.ox) report_mismatch("out_x", m_out_x, ex.ox);
                    if (m_out_y != ex.oy) report_mismatch("out_y", m_out_y, ex.oy);
                    if (m_out_z != ex.oz) report_mismatch("out_z", m_out_z, ex.oz);
                    if (m_out_qw != ex.qw) report_mismatch("out_qw", m_out_qw, ex.qw);
                    if (m_out_qx != ex.qx) report_mismatch("out_qx", m_out_qx, ex.qx);
                    if (m_out_qy != ex.qy) report_mismatch("out_qy", m_out_qy, ex.qy);
                    if (m_out_qz != ex.qz) report_mismatch("out_qz", m_out_qz, ex.qz);
                end
            end
        end
    end

    // request driver
    always @(negedge aclk) begin
        pose_req_t rq;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || req_taken) begin
            if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                rq = pending_q.pop_front();
                s_pos_x <= rq.px; s_pos_y <= rq.py; s_pos_z <= rq.pz;
                s_quat_w <= rq.qw; s_quat_x <= rq.qx; s_quat_y <= rq.qy; s_quat_z <= rq.qz;
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result receiver, with one long hold-off
    always @(negedge aclk) begin
        if (hold_start) begin
            hold_start = 1'b0;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    function automatic pose_req_t make_req(input int px, input int py, input int pz,
                                           input int qw, input int qx, input int qy,
                                           input int qz);
        pose_req_t rq;
        rq.px = px; rq.py = py; rq.pz = pz;
        rq.qw = 16'(qw); rq.qx = 16'(qx); rq.qy = 16'(qy); rq.qz = 16'(qz);
        return rq;
    endfunction

    function automatic int rand_comp();
        return int'($urandom_range(0, 32768)) - 16384;
    endfunction

    // random pose, mostly unit quaternions, some raw or degenerate ones
    function automatic pose_req_t rand_req();
        pose_req_t rq;
        real rw, rx, ry, rz, n;
        int sel;
        sel = $urandom_range(0, 99);
        rq.px = $urandom; rq.py = $urandom; rq.pz = $urandom;
        if ($urandom_range(0, 19) == 0) rq.py = 32'sh80000000;
        if (sel < 70) begin
            rw = rand_comp(); rx = rand_comp(); ry = rand_comp(); rz = rand_comp();
            if ($urandom_range(0, 3) == 0) rz = 0.0;
            if ($urandom_range(0, 3) == 0) rx = 0.0;
            n = $sqrt(rw * rw + rx * rx + ry * ry + rz * rz);
            if (n < 1.0) begin
                rw = 1.0; n = 1.0;
            end
            rq.qw = 16'(int'(16384.0 * rw / n));
            rq.qx = 16'(int'(16384.0 * rx / n));
            rq.qy = 16'(int'(16384.0 * ry / n));
            rq.qz = 16'(int'(16384.0 * rz / n));
        end else if (sel < 90) begin
            rq.qw = 16'(rand_comp()); rq.qx = 16'(rand_comp());
            rq.qy = 16'(rand_comp()); rq.qz = 16'(rand_comp());
        end else begin
            rq.qw = ($urandom_range(0, 1) != 0) ? 16'sd16384 : -16'sd16384;
            rq.qx = 16'(($urandom_range(0, 2) - 1) * 16384);
            rq.qy = 16'(($urandom_range(0, 2) - 1) * 16384);
            rq.qz = 16'(($urandom_range(0, 2) - 1) * 16384);
        end
        return rq;
    endfunction

    // wait for the pipeline to drain, then write the yaw offset
    task automatic write_yaw_offset(input logic signed [17:0] v);
        wait (pending_q.size() == 0 && !s_valid && rotated_q.size() == 0);
        repeat (PIPE_WAIT) @(posedge aclk);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_we <= 1'b0;
        yaw_offset_reg = v;
    endtask

    // stimulus
    initial begin
        logic signed [17:0] offsets [8];
        int idle_mode;
        offsets = '{18'sd16384, 18'sd0, 18'sd65536, -18'sd65536, -18'sd1,
                    18'sd32768, 18'sd0, 18'sd0};
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed poses: position extremes, degenerate and axis quaternions
        pending_q.push_back(make_req(32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000,
                                     16384, 0, 0, 0));
        pending_q.push_back(make_req(32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                                     -16384, 0, 0, 0));
        pending_q.push_back(make_req(0, 0, 0, 0, 0, 0, 0));
        pending_q.push_back(make_req(-1, -1, -1, 0, 16384, 0, 0));
        pending_q.push_back(make_req(1, 1, 1, 0, 0, 16384, 0));
        pending_q.push_back(make_req(65536, -65536, 0, 0, 0, 0, 16384));
        pending_q.push_back(make_req(0, 32'sh80000000, 0, 0, -16384, 0, 0));
        pending_q.push_back(make_req(0, 0, 0, 0, 0, -16384, 0));
        pending_q.push_back(make_req(0, 0, 0, 0, 0, 0, -16384));
        pending_q.push_back(make_req(5, 7, 9, 16384, -16384, 16384, -16384));
        pending_q.push_back(make_req(5, 7, 9, 16384, 16384, 16384, 16384));
        pending_q.push_back(make_req(5, 7, 9, -16384, -16384, -16384, -16384));
        pending_q.push_back(make_req(3, 4, 5, 11585, 0, 11585, 0));
        pending_q.push_back(make_req(3, 4, 5, 11585, 0, -11585, 0));
        pending_q.push_back(make_req(3, 4, 5, 11585, 11585, 0, 0));
        pending_q.push_back(make_req(3, 4, 5, 11585, 0, 0, 11585));
        pending_q.push_back(make_req(3, 4, 5, 11585, 0, 0, -11585));
        pending_q.push_back(make_req(3, 4, 5, 8192, 8192, 8192, 8192));
        pending_q.push_back(make_req(3, 4, 5, 1, 0, 0, 0));
        pending_q.push_back(make_req(3, 4, 5, -16384, 0, 0, 1));

        for (int ph = 0; ph < 8; ph++) begin
            if (ph != 0) begin
                if (ph >= 6) offsets[ph] = 18'(int'($urandom_range(0, 131072)) - 65536);
                write_yaw_offset(offsets[ph]);
            end
            idle_mode = ph % 4;
            send_idle_pct  = (idle_mode == 1) ? 77 : (idle_mode == 3) ? 26 : 0;
            recv_stall_pct = (idle_mode == 2) ? 77 : (idle_mode == 3) ? 26 : 0;
            if (ph == 4) begin
                @(posedge aclk);
                hold_start = 1'b1;
            end
            for (int i = 0; i < 230; i++) pending_q.push_back(rand_req());
        end

        wait (pending_q.size() == 0 && !s_valid && rotated_q.size() == 0);
        repeat (PIPE_WAIT) @(posedge aclk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // run limit
    initial begin
        #10_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire

[pose_frame_rotation_core.f]
+incdir+src
src/pfr_pkg.sv
src/pfr_atan2.sv
src/pfr_sincos.sv
src/pose_frame_rotation_core.sv
bench/tb.sv
